FILE: hdl/pmu_pkg.sv
package pmu_pkg;

    // fixed-point formats
    localparam int TRIG_FRAC    = 28;
    localparam int ATAN_ENTRIES = 24;

    localparam longint PI_Q29                = 64'sd1686629713;
    localparam logic signed [31:0] PI_Q28      = 32'sd843314857;
    localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;
    localparam logic signed [31:0] GAIN_Q28    = 32'sd163008219;

    // arctangent of 2^-i, Q28 radians
    localparam logic signed [31:0] ATAN_Q28 [ATAN_ENTRIES] = '{
        32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
        32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
        32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
        32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
        32'sd4096,      32'sd2048,      32'sd1024,     32'sd512,
        32'sd256,       32'sd128,       32'sd64,       32'sd32
    };

    // configuration register indexes
    typedef logic [2:0] t_cfg_index;
    localparam t_cfg_index CFG_DELTA_X     = 3'd0;
    localparam t_cfg_index CFG_DELTA_Y     = 3'd1;
    localparam t_cfg_index CFG_DELTA_TURN  = 3'd2;
    localparam t_cfg_index CFG_SPREAD_X    = 3'd3;
    localparam t_cfg_index CFG_SPREAD_Y    = 3'd4;
    localparam t_cfg_index CFG_SPREAD_TURN = 3'd5;

    // configuration registers as seen by the front stage
    typedef struct packed {
        logic [31:0] delta_x;
        logic [31:0] delta_y;
        logic [15:0] delta_turn;
        logic [23:0] spread_x;
        logic [23:0] spread_y;
        logic [15:0] spread_turn;
    } t_cfg;

    // payload handed from cell to cell (all numeric fields two's complement)
    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        flip;
        logic [31:0] pose_x;
        logic [31:0] pose_y;
        logic [31:0] dx;
        logic [31:0] dy;
        logic [15:0] heading;
    } t_cell;

    // pi in the angle format, rounded
    function automatic longint pi_angle(input int afb);
        return (PI_Q29 + (64'sd1 <<< (28 - afb))) >>> (29 - afb);
    endfunction

    // saturate to the 32-bit signed range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] res;
        if (v > 64'sd2147483647) begin
            res = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

FILE: hdl/pmu_front.sv
module pmu_front #(
    parameter int ANGLE_FRAC_BITS = 13
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pmu_pkg::t_cfg       i_cfg,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [31:0]  i_pose_x,
    input  logic signed [31:0]  i_pose_y,
    input  logic signed [15:0]  i_pose_heading,
    input  logic signed [15:0]  i_noise_fwd,
    input  logic signed [15:0]  i_noise_side,
    input  logic signed [15:0]  i_noise_rot,
    output logic                o_valid,
    input  logic                i_ready,
    output pmu_pkg::t_cell      o_cell
);
    import pmu_pkg::*;

    localparam int AW  = (ANGLE_FRAC_BITS + 4 > 17) ? ANGLE_FRAC_BITS + 4 : 17;
    localparam int TSH = 24 - ANGLE_FRAC_BITS;
    localparam int ZSH = TRIG_FRAC - ANGLE_FRAC_BITS;
    localparam longint PI_VAL = pi_angle(ANGLE_FRAC_BITS);
    localparam logic signed [AW-1:0] PI_A     = AW'(PI_VAL);
    localparam logic signed [AW-1:0] TWO_PI_A = AW'(2 * PI_VAL);
    localparam logic signed [33:0]   PI_T     = 34'(PI_VAL);
    localparam logic signed [32:0]   TURN_HALF = 33'sd1 <<< (TSH - 1);

    // stage 0: products and heading clamp
    logic                 r_s0_valid;
    logic signed [31:0]   r_s0_pose_x, r_s0_pose_y;
    logic signed [AW-1:0] r_s0_head;
    logic signed [40:0]   r_s0_px, r_s0_py;
    logic signed [32:0]   r_s0_pt;
    logic signed [AW-1:0] n_s0_head;
    logic signed [AW-1:0] head_ext;

    // stage 1: noisy motion, heading update, cordic start vector
    logic                 r_s1_valid;
    t_cell                r_s1_cell;
    t_cell                n_s1_cell;

    logic s0_ready, s1_ready;

    assign s1_ready = !r_s1_valid || i_ready;
    assign s0_ready = !r_s0_valid || s1_ready;
    assign o_ready  = s0_ready;
    assign o_valid  = r_s1_valid;
    assign o_cell   = r_s1_cell;

    // heading clamp to [-pi, pi]
    always_comb begin
        head_ext = AW'(i_pose_heading);
        if (head_ext > PI_A) begin
            n_s0_head = PI_A;
        end else if (head_ext < -PI_A) begin
            n_s0_head = -PI_A;
        end else begin
            n_s0_head = head_ext;
        end
    end

    // noise and motion arithmetic of stage 1
    logic signed [40:0]   px_rnd, py_rnd;
    logic signed [41:0]   dx_sum, dy_sum;
    logic signed [32:0]   turn_rnd;
    logic signed [33:0]   turn_sum;
    logic signed [AW-1:0] turn, head_sum, head_wrap;
    logic signed [31:0]   z_raw, z_fold;
    logic                 flip;

    always_comb begin
        px_rnd = (r_s0_px + 41'sd2048) >>> 12;
        py_rnd = (r_s0_py + 41'sd2048) >>> 12;
        dx_sum = 42'($signed(i_cfg.delta_x)) + 42'(px_rnd);
        dy_sum = 42'($signed(i_cfg.delta_y)) + 42'(py_rnd);

        // noisy turn, clamped to +-pi
        turn_rnd = (r_s0_pt + TURN_HALF) >>> TSH;
        turn_sum = 34'($signed(i_cfg.delta_turn)) + 34'(turn_rnd);
        if (turn_sum > PI_T) begin
            turn = PI_A;
        end else if (turn_sum < -PI_T) begin
            turn = -PI_A;
        end else begin
            turn = AW'(turn_sum);
        end

        // one wrap step into (-pi, pi]
        head_sum = r_s0_head + turn;
        if (head_sum > PI_A) begin
            head_wrap = head_sum - TWO_PI_A;
        end else if (head_sum <= -PI_A) begin
            head_wrap = head_sum + TWO_PI_A;
        end else begin
            head_wrap = head_sum;
        end

        // fold the heading into +-pi/2
        z_raw = 32'(r_s0_head) <<< ZSH;
        if (z_raw > HALF_PI_Q28) begin
            z_fold = z_raw - PI_Q28;
            flip   = 1'b1;
        end else if (z_raw < -HALF_PI_Q28) begin
            z_fold = z_raw + PI_Q28;
            flip   = 1'b1;
        end else begin
            z_fold = z_raw;
            flip   = 1'b0;
        end

        n_s1_cell         = '0;
        n_s1_cell.x       = GAIN_Q28;
        n_s1_cell.y       = '0;
        n_s1_cell.z       = z_fold;
        n_s1_cell.flip    = flip;
        n_s1_cell.pose_x  = r_s0_pose_x;
        n_s1_cell.pose_y  = r_s0_pose_y;
        n_s1_cell.dx      = sat32(64'(dx_sum));
        n_s1_cell.dy      = sat32(64'(dy_sum));
        n_s1_cell.heading = head_wrap[15:0];
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            if (s0_ready) begin
                r_s0_valid <= i_valid;
            end
            if (s1_ready) begin
                r_s1_valid <= r_s0_valid;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s0_ready && i_valid) begin
            r_s0_pose_x <= i_pose_x;
            r_s0_pose_y <= i_pose_y;
            r_s0_head   <= n_s0_head;
            r_s0_px     <= 41'(i_noise_fwd)  * 41'($signed({1'b0, i_cfg.spread_x}));
            r_s0_py     <= 41'(i_noise_side) * 41'($signed({1'b0, i_cfg.spread_y}));
            r_s0_pt     <= 33'(i_noise_rot)  * 33'($signed({1'b0, i_cfg.spread_turn}));
        end
        if (s1_ready && r_s0_valid) begin
            r_s1_cell <= n_s1_cell;
        end
    end

endmodule

FILE: hdl/pmu_cordic_cell.sv
module pmu_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  pmu_pkg::t_cell i_cell,
    output logic           o_valid,
    input  logic           i_ready,
    output pmu_pkg::t_cell o_cell
);
    import pmu_pkg::*;

    localparam logic signed [31:0] ATAN_I = ATAN_Q28[STAGE];

    logic  r_valid;
    t_cell r_cell;
    t_cell n_cell;
    logic  ready;

    logic signed [31:0] x_in, y_in, z_in, xs, ys;

    assign ready   = !r_valid || i_ready;
    assign o_ready = ready;
    assign o_valid = r_valid;
    assign o_cell  = r_cell;

    // one rotation-mode iteration
    always_comb begin
        x_in   = $signed(i_cell.x);
        y_in   = $signed(i_cell.y);
        z_in   = $signed(i_cell.z);
        xs     = x_in >>> STAGE;
        ys     = y_in >>> STAGE;
        n_cell = i_cell;
        if (z_in >= 0) begin
            n_cell.x = x_in - ys;
            n_cell.y = y_in + xs;
            n_cell.z = z_in - ATAN_I;
        end else begin
            n_cell.x = x_in + ys;
            n_cell.y = y_in - xs;
            n_cell.z = z_in + ATAN_I;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready && i_valid) begin
            r_cell <= n_cell;
        end
    end

endmodule

FILE: hdl/pmu_rotate.sv
module pmu_rotate (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  pmu_pkg::t_cell     i_cell,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_moved_x,
    output logic signed [31:0] o_moved_y,
    output logic signed [15:0] o_moved_heading
);
    import pmu_pkg::*;

    localparam logic signed [63:0] HALF = 64'sd1 <<< (TRIG_FRAC - 1);

    // stage 1: four products
    logic               r_s1_valid;
    logic signed [63:0] r_s1_xdx, r_s1_ydy, r_s1_ydx, r_s1_xdy;
    logic               r_s1_flip;
    logic signed [31:0] r_s1_pose_x, r_s1_pose_y;
    logic        [15:0] r_s1_heading;

    // stage 2: rotated motion before rounding
    logic               r_s2_valid;
    logic signed [63:0] r_s2_vx, r_s2_vy;
    logic               r_s2_flip;
    logic signed [31:0] r_s2_pose_x, r_s2_pose_y;
    logic        [15:0] r_s2_heading;

    // stage 3: rounded global motion
    logic               r_s3_valid;
    logic signed [35:0] r_s3_gx, r_s3_gy;
    logic signed [31:0] r_s3_pose_x, r_s3_pose_y;
    logic        [15:0] r_s3_heading;

    // stage 4: output register
    logic               r_s4_valid;
    logic signed [31:0] r_s4_x, r_s4_y;
    logic        [15:0] r_s4_heading;

    logic s1_ready, s2_ready, s3_ready, s4_ready;

    assign s4_ready = !r_s4_valid || i_ready;
    assign s3_ready = !r_s3_valid || s4_ready;
    assign s2_ready = !r_s2_valid || s3_ready;
    assign s1_ready = !r_s1_valid || s2_ready;
    assign o_ready  = s1_ready;

    assign o_valid         = r_s4_valid;
    assign o_moved_x       = r_s4_x;
    assign o_moved_y       = r_s4_y;
    assign o_moved_heading = $signed(r_s4_heading);

    // folded angle negates both sine and cosine, so negate the sums
    logic signed [63:0] n_s3_tx, n_s3_ty;

    always_comb begin
        n_s3_tx = (r_s2_flip ? ~r_s2_vx : r_s2_vx) + HALF + 64'(r_s2_flip);
        n_s3_ty = (r_s2_flip ? ~r_s2_vy : r_s2_vy) + HALF + 64'(r_s2_flip);
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_valid;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
            if (s3_ready) begin
                r_s3_valid <= r_s2_valid;
            end
            if (s4_ready) begin
                r_s4_valid <= r_s3_valid;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s1_ready && i_valid) begin
            r_s1_xdx     <= 64'($signed(i_cell.x)) * 64'($signed(i_cell.dx));
            r_s1_ydy     <= 64'($signed(i_cell.y)) * 64'($signed(i_cell.dy));
            r_s1_ydx     <= 64'($signed(i_cell.y)) * 64'($signed(i_cell.dx));
            r_s1_xdy     <= 64'($signed(i_cell.x)) * 64'($signed(i_cell.dy));
            r_s1_flip    <= i_cell.flip;
            r_s1_pose_x  <= $signed(i_cell.pose_x);
            r_s1_pose_y  <= $signed(i_cell.pose_y);
            r_s1_heading <= i_cell.heading;
        end
        if (s2_ready && r_s1_valid) begin
            r_s2_vx      <= r_s1_xdx - r_s1_ydy;
            r_s2_vy      <= r_s1_ydx + r_s1_xdy;
            r_s2_flip    <= r_s1_flip;
            r_s2_pose_x  <= r_s1_pose_x;
            r_s2_pose_y  <= r_s1_pose_y;
            r_s2_heading <= r_s1_heading;
        end
        if (s3_ready && r_s2_valid) begin
            r_s3_gx      <= 36'(n_s3_tx >>> TRIG_FRAC);
            r_s3_gy      <= 36'(n_s3_ty >>> TRIG_FRAC);
            r_s3_pose_x  <= r_s2_pose_x;
            r_s3_pose_y  <= r_s2_pose_y;
            r_s3_heading <= r_s2_heading;
        end
        if (s4_ready && r_s3_valid) begin
            r_s4_x       <= sat32(64'(r_s3_pose_x) + 64'(r_s3_gx));
            r_s4_y       <= sat32(64'(r_s3_pose_y) + 64'(r_s3_gy));
            r_s4_heading <= r_s3_heading;
        end
    end

endmodule

FILE: hdl/particle_motion_update_core.sv
// Particle motion update: each beat carries one particle pose and three
// standard-normal samples; the result beat carries the moved pose. One beat
// is taken per clock while the output side keeps up. Each result passes
// through the noise-product and noisy-motion stages, one cell per CORDIC
// iteration for the heading's sine and cosine, and the stages for the 32x32
// rotation products, their sums, rounding and the saturating add to the
// position. Every stage holds its own valid bit and stalls only when the
// stage after it is full and stalled, so input beats keep flowing into
// empty stages while a result waits at the output. The user must write the
// odometry deltas and spreads through the configuration port only while no
// beat is in flight; the block does not enforce this. Unknown register
// indexes are ignored.
module particle_motion_update_core #(
    parameter int CORDIC_STAGES   = 16,
    parameter int ANGLE_FRAC_BITS = 13
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  pmu_pkg::t_cfg_index   i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic signed [31:0]    i_pose_x,
    input  logic signed [31:0]    i_pose_y,
    input  logic signed [15:0]    i_pose_heading,
    input  logic signed [15:0]    i_noise_fwd,
    input  logic signed [15:0]    i_noise_side,
    input  logic signed [15:0]    i_noise_rot,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic signed [31:0]    o_moved_x,
    output logic signed [31:0]    o_moved_y,
    output logic signed [15:0]    o_moved_heading
);
    import pmu_pkg::*;

    t_cfg  r_cfg;
    logic  front_ready;
    t_cell chain_cell  [CORDIC_STAGES+1];
    logic  chain_valid [CORDIC_STAGES+1];
    logic  chain_ready [CORDIC_STAGES+1];

    assign o_stall = !front_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DELTA_X:     r_cfg.delta_x     <= i_cfg_data;
                CFG_DELTA_Y:     r_cfg.delta_y     <= i_cfg_data;
                CFG_DELTA_TURN:  r_cfg.delta_turn  <= i_cfg_data[15:0];
                CFG_SPREAD_X:    r_cfg.spread_x    <= i_cfg_data[23:0];
                CFG_SPREAD_Y:    r_cfg.spread_y    <= i_cfg_data[23:0];
                CFG_SPREAD_TURN: r_cfg.spread_turn <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // noisy motion and heading update
    pmu_front #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (i_valid),
        .o_ready        (front_ready),
        .i_pose_x       (i_pose_x),
        .i_pose_y       (i_pose_y),
        .i_pose_heading (i_pose_heading),
        .i_noise_fwd    (i_noise_fwd),
        .i_noise_side   (i_noise_side),
        .i_noise_rot    (i_noise_rot),
        .o_valid        (chain_valid[0]),
        .i_ready        (chain_ready[0]),
        .o_cell         (chain_cell[0])
    );

    // cordic chain, one iteration per cell
    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
        pmu_cordic_cell #(
            .STAGE (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[k]),
            .o_ready (chain_ready[k]),
            .i_cell  (chain_cell[k]),
            .o_valid (chain_valid[k+1]),
            .i_ready (chain_ready[k+1]),
            .o_cell  (chain_cell[k+1])
        );
    end

    // rotation into the world frame and position update
    pmu_rotate u_rotate (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (chain_valid[CORDIC_STAGES]),
        .o_ready         (chain_ready[CORDIC_STAGES]),
        .i_cell          (chain_cell[CORDIC_STAGES]),
        .o_valid         (o_valid),
        .i_ready         (!i_stall),
        .o_moved_x       (o_moved_x),
        .o_moved_y       (o_moved_y),
        .o_moved_heading (o_moved_heading)
    );

endmodule

FILE: hdl/pmu_checker.sv
module pmu_checker #(
    parameter int ANGLE_FRAC_BITS = 13
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_stall,
    input logic               i_out_valid,
    input logic               i_out_stall,
    input logic signed [31:0] i_moved_x,
    input logic signed [31:0] i_moved_y,
    input logic signed [15:0] i_moved_heading
);
    import pmu_pkg::*;

    localparam int PI_CODE = int'(pi_angle(ANGLE_FRAC_BITS));

    // a stalled result beat stays valid
    a_out_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps its payload
    a_out_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=>
            $stable(i_moved_x) && $stable(i_moved_y) && $stable(i_moved_heading))
        else $error("result payload changed while stalled");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat right after reset");

    // input is only held back when the output is stalled
    a_no_spurious_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_stall |-> !i_in_stall)
        else $error("input stalled with output free");

    // heading lands in (-pi, pi], checked only for ANGLE_FRAC_BITS up to 13
    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (ANGLE_FRAC_BITS > 13) ||
            ((i_moved_heading > -PI_CODE) && (i_moved_heading <= PI_CODE)))
        else $error("heading outside (-pi, pi]");

endmodule

bind particle_motion_update_core pmu_checker #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
) u_pmu_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_stall      (o_stall),
    .i_out_valid     (o_valid),
    .i_out_stall     (i_stall),
    .i_moved_x       (o_moved_x),
    .i_moved_y       (o_moved_y),
    .i_moved_heading (o_moved_heading)
);
